[rtl/multimode_seven_segment_scanner_macros.svh]
// Assertion macros for the seven-segment scanner RTL.
`ifndef MULTIMODE_SEVEN_SEGMENT_SCANNER_MACROS_SVH
`define MULTIMODE_SEVEN_SEGMENT_SCANNER_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define MSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mss assertion failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define MSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mss assertion failed");

`endif

[rtl/mss_pkg.sv]
// Constants, codes and segment decode for the seven-segment scanner.
package mss_pkg;

    localparam int ValueW = 16;
    localparam int SegW   = 8;
    localparam int BcdW   = 20;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // Item kinds.
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_SWITCH = 2'd1;
    localparam logic [1:0] KIND_BUTTON = 2'd2;

    // Display modes.
    localparam logic [2:0] MODE_HEX    = 3'd0;
    localparam logic [2:0] MODE_DEC    = 3'd1;
    localparam logic [2:0] MODE_SHIFT  = 3'd2;
    localparam logic [2:0] MODE_BYTE   = 3'd3;
    localparam logic [2:0] MODE_SCROLL = 3'd4;

    localparam logic [SegW-1:0] SEG_BLANK = 8'hFF;
    localparam logic [SegW-1:0] SEG_MINUS = 8'hBF;
    localparam logic [7:0] SCROLL_PERIOD_RESET = 8'd200;

    function automatic logic [SegW-1:0] hex_seg(input logic [3:0] nib);
        logic [SegW-1:0] s;
        case (nib)
            4'h0: s = 8'hC0;
            4'h1: s = 8'hF9;
            4'h2: s = 8'hA4;
            4'h3: s = 8'hB0;
            4'h4: s = 8'h99;
            4'h5: s = 8'h92;
            4'h6: s = 8'h82;
            4'h7: s = 8'hF8;
            4'h8: s = 8'h80;
            4'h9: s = 8'h90;
            4'hA: s = 8'h88;
            4'hB: s = 8'h83;
            4'hC: s = 8'hC6;
            4'hD: s = 8'hA1;
            4'hE: s = 8'h86;
            4'hF: s = 8'h8E;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    function automatic logic [SegW-1:0] scroll_seg(input logic [1:0] idx);
        logic [SegW-1:0] s;
        case (idx)
            2'd0: s = 8'hB0;
            2'd1: s = 8'h99;
            2'd2: s = 8'h92;
            2'd3: s = 8'h82;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

[rtl/multimode_seven_segment_scanner.sv]
// Eight-digit multiplexed seven-segment scanner with five display modes.
//
// Usage: items arrive on the s_ stream. tuser carries the kind (scan tick,
// switch update, button press); tdata carries the switch value and buttons.
// Each scan tick produces one transfer on the m_ stream holding the active-low
// digit enable, the active-low segments of that digit and the LED mirror of
// the latched switch value. Switch and button items produce no transfer.
// The user writes the scroll period over the cfg_ channel only while the block is
// idle; the block itself does not enforce this. Switch and button items are
// handled in the idle state. A scan tick goes straight to the emit state in the
// hex, shift, byte and scroll modes; in signed decimal mode a shift-and-add-3
// unit first runs sixteen steps. The block takes one item at a time and s_tready
// is low meanwhile. A finished result sits in the output register, so switch and
// button items are still accepted while the receiver stalls; a following tick is
// accepted but holds in the emit state until the output register is free.
// Reset (rst_n low, asynchronous) returns to hex mode, position 0, with the
// counters and the latched and shift values cleared and the scroll period at 200.
module multimode_seven_segment_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] switch_value, [20:16] buttons, [23:21] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] digit_select, [15:8] segments, [31:16] led_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic [1:0]  state_reg, state_next;
    logic [2:0]  scan_pos_reg, scan_pos_next;
    logic [15:0] latched_reg, latched_next;
    logic [2:0]  mode_reg, mode_next;
    logic        shift_right_reg, shift_right_next;
    logic [15:0] shifting_reg, shifting_next;
    logic [7:0]  frame_cnt_reg, frame_cnt_next;
    logic [1:0]  scroll_step_reg, scroll_step_next;
    logic [7:0]  period_reg, period_next;
    logic [15:0] bin_reg, bin_next;
    logic [19:0] bcd_reg, bcd_next;
    logic [3:0]  step_cnt_reg, step_cnt_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    logic        s_xfer;
    logic        out_free;
    logic [15:0] mag;
    logic [19:0] bcd_adj;
    logic [4:0]  buttons;
    logic [15:0] shifted_pattern;
    logic [15:0] hex_src;
    logic [3:0]  nib;
    logic [2:0]  n_dig;
    logic [3:0]  pos_plus_n;
    logic [3:0]  dec_digit;
    logic [7:0]  seg;
    logic [7:0]  frame_inc;

    assign s_tready  = (state_reg == mss_pkg::ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign buttons   = s_tdata[20:16];

    assign mag = latched_reg[15] ? 16'(~latched_reg + 16'd1) : latched_reg;

    // Shift-and-add-3 correction: each BCD digit of five or more gets three added.
    always_comb
    begin
        for (int d = 0; d < 5; d++)
        begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ?
                                4'(bcd_reg[4*d +: 4] + 4'd3) : bcd_reg[4*d +: 4];
        end
    end

    // Digit count of the decimal magnitude (zero still shows one digit).
    always_comb
    begin
        if (bcd_reg[19:16] != 4'd0)
            n_dig = 3'd5;
        else if (bcd_reg[15:12] != 4'd0)
            n_dig = 3'd4;
        else if (bcd_reg[11:8] != 4'd0)
            n_dig = 3'd3;
        else if (bcd_reg[7:4] != 4'd0)
            n_dig = 3'd2;
        else
            n_dig = 3'd1;
    end

    assign pos_plus_n = {1'b0, scan_pos_reg} + {1'b0, n_dig};

    // Negative values are left-shifted one place to make room for the minus.
    always_comb
    begin
        logic [2:0] idx;
        idx = latched_reg[15] ? 3'(3'd3 - scan_pos_reg) : 3'(3'd4 - scan_pos_reg);
        case (idx)
            3'd0: dec_digit = bcd_reg[3:0];
            3'd1: dec_digit = bcd_reg[7:4];
            3'd2: dec_digit = bcd_reg[11:8];
            3'd3: dec_digit = bcd_reg[15:12];
            3'd4: dec_digit = bcd_reg[19:16];
            default: dec_digit = 4'd0;
        endcase
    end

    // The shift mode moves its pattern once per frame, at position 0.
    always_comb
    begin
        shifted_pattern = shifting_reg;
        if (mode_reg == mss_pkg::MODE_SHIFT && scan_pos_reg == 3'd0 && frame_cnt_reg == 8'd0)
        begin
            shifted_pattern = shift_right_reg ? {1'b0, shifting_reg[15:1]}
                                              : {shifting_reg[14:0], 1'b0};
        end
    end

    always_comb
    begin
        case (mode_reg)
            mss_pkg::MODE_SHIFT: hex_src = shifted_pattern;
            mss_pkg::MODE_BYTE:  hex_src = {latched_reg[7:0], latched_reg[7:0]};
            default:             hex_src = latched_reg;
        endcase
        case (scan_pos_reg[1:0])
            2'd0:    nib = hex_src[15:12];
            2'd1:    nib = hex_src[11:8];
            2'd2:    nib = hex_src[7:4];
            default: nib = hex_src[3:0];
        endcase
    end

    always_comb
    begin
        seg = mss_pkg::SEG_BLANK;
        case (mode_reg)
            mss_pkg::MODE_HEX, mss_pkg::MODE_SHIFT, mss_pkg::MODE_BYTE:
            begin
                if (!scan_pos_reg[2])
                    seg = mss_pkg::hex_seg(nib);
            end
            mss_pkg::MODE_DEC:
            begin
                if (latched_reg[15])
                begin
                    // Only positions 0..3 take magnitude digits; a five-digit magnitude
                    // shows three of them over the minus and leaves position 3 blank.
                    if (scan_pos_reg <= 3'd3 && pos_plus_n >= 4'd4
                        && !(n_dig == 3'd5 && scan_pos_reg == 3'd3))
                        seg = mss_pkg::hex_seg(dec_digit);
                    else if (scan_pos_reg == 3'd0)
                        seg = mss_pkg::SEG_MINUS;
                end
                else if (scan_pos_reg <= 3'd4 && pos_plus_n >= 4'd5)
                begin
                    seg = mss_pkg::hex_seg(dec_digit);
                end
            end
            mss_pkg::MODE_SCROLL:
            begin
                if (!scan_pos_reg[2])
                    seg = mss_pkg::scroll_seg(2'(scroll_step_reg + scan_pos_reg[1:0]));
            end
            default: seg = mss_pkg::SEG_BLANK;
        endcase
    end

    assign frame_inc = (frame_cnt_reg == 8'hFF) ? frame_cnt_reg : 8'(frame_cnt_reg + 8'd1);

    always_comb
    begin
        state_next       = state_reg;
        scan_pos_next    = scan_pos_reg;
        latched_next     = latched_reg;
        mode_next        = mode_reg;
        shift_right_next = shift_right_reg;
        shifting_next    = shifting_reg;
        frame_cnt_next   = frame_cnt_reg;
        scroll_step_next = scroll_step_reg;
        period_next      = period_reg;
        bin_next         = bin_reg;
        bcd_next         = bcd_reg;
        step_cnt_next    = step_cnt_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;

        if (cfg_valid && cfg_ready)
            period_next = cfg_data;

        case (state_reg)
            mss_pkg::ST_IDLE:
            begin
                if (s_xfer)
                begin
                    case (s_tuser)
                        mss_pkg::KIND_SWITCH: latched_next = s_tdata[15:0];
                        mss_pkg::KIND_BUTTON:
                        begin
                            if (buttons[0])
                            begin
                                mode_next     = mss_pkg::MODE_HEX;
                                shifting_next = latched_reg;
                            end
                            else if (buttons[1])
                            begin
                                mode_next     = mss_pkg::MODE_DEC;
                                shifting_next = latched_reg;
                            end
                            else if (buttons[2])
                            begin
                                mode_next        = mss_pkg::MODE_SHIFT;
                                shift_right_next = latched_reg[15];
                                shifting_next    = latched_reg;
                            end
                            else if (buttons[3])
                            begin
                                mode_next     = mss_pkg::MODE_BYTE;
                                shifting_next = latched_reg;
                            end
                            else if (buttons[4])
                            begin
                                mode_next = mss_pkg::MODE_SCROLL;
                            end
                        end
                        mss_pkg::KIND_TICK:
                        begin
                            if (mode_reg == mss_pkg::MODE_DEC)
                            begin
                                bin_next      = mag;
                                bcd_next      = '0;
                                step_cnt_next = '0;
                                state_next    = mss_pkg::ST_CONV;
                            end
                            else
                            begin
                                state_next = mss_pkg::ST_EMIT;
                            end
                        end
                        default: state_next = mss_pkg::ST_IDLE;
                    endcase
                end
            end
            mss_pkg::ST_CONV:
            begin
                bcd_next      = {bcd_adj[18:0], bin_reg[15]};
                bin_next      = {bin_reg[14:0], 1'b0};
                step_cnt_next = 4'(step_cnt_reg + 4'd1);
                if (step_cnt_reg == 4'd15)
                    state_next = mss_pkg::ST_EMIT;
            end
            mss_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {latched_reg, seg, ~(8'h80 >> scan_pos_reg)};
                    shifting_next = shifted_pattern;
                    scan_pos_next = 3'(scan_pos_reg + 3'd1);
                    if (scan_pos_reg == 3'd7)
                    begin
                        frame_cnt_next = frame_inc;
                        if (mode_reg == mss_pkg::MODE_SCROLL && frame_inc >= period_reg)
                        begin
                            frame_cnt_next   = 8'd0;
                            scroll_step_next = 2'(scroll_step_reg + 2'd1);
                        end
                        else if (mode_reg == mss_pkg::MODE_SHIFT)
                        begin
                            frame_cnt_next = 8'd0;
                        end
                    end
                    state_next = mss_pkg::ST_IDLE;
                end
            end
            default: state_next = mss_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mss_pkg::ST_IDLE;
            scan_pos_reg    <= '0;
            latched_reg     <= '0;
            mode_reg        <= mss_pkg::MODE_HEX;
            shift_right_reg <= 1'b0;
            shifting_reg    <= '0;
            frame_cnt_reg   <= '0;
            scroll_step_reg <= '0;
            period_reg      <= mss_pkg::SCROLL_PERIOD_RESET;
            step_cnt_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_pos_reg    <= scan_pos_next;
            latched_reg     <= latched_next;
            mode_reg        <= mode_next;
            shift_right_reg <= shift_right_next;
            shifting_reg    <= shifting_next;
            frame_cnt_reg   <= frame_cnt_next;
            scroll_step_reg <= scroll_step_next;
            period_reg      <= period_next;
            step_cnt_reg    <= step_cnt_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        m_tdata_reg <= m_tdata_next;
    end

`include "multimode_seven_segment_scanner_macros.svh"

    `MSS_ASSERT_NOW(a_digit_one_cold, m_tvalid_reg, $onehot(~m_tdata_reg[7:0]))
    `MSS_ASSERT_NEXT(a_dec_tick_converts,
        s_xfer && s_tuser == mss_pkg::KIND_TICK && mode_reg == mss_pkg::MODE_DEC,
        state_reg == mss_pkg::ST_CONV && step_cnt_reg == 4'd0)
    `MSS_ASSERT_NEXT(a_pos_advances, state_reg == mss_pkg::ST_EMIT && out_free,
        scan_pos_reg == 3'($past(scan_pos_reg) + 3'd1) && m_tvalid_reg)
    `MSS_ASSERT_NEXT(a_shift_frame_clear,
        state_reg == mss_pkg::ST_EMIT && out_free && scan_pos_reg == 3'd7
            && mode_reg == mss_pkg::MODE_SHIFT,
        frame_cnt_reg == 8'd0)

endmodule

[tb/testbench.sv]
// Self-checking testbench for the multimode seven-segment scanner.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Kind 3 has no meaning for the block and must be dropped without a result.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [4:0] BTN_HEX    = 5'b00001;
    localparam logic [4:0] BTN_DEC    = 5'b00010;
    localparam logic [4:0] BTN_SHIFT  = 5'b00100;
    localparam logic [4:0] BTN_BYTE   = 5'b01000;
    localparam logic [4:0] BTN_SCROLL = 5'b10000;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [7:0]  digit_select;
        logic [7:0]  segments;
        logic [15:0] led_value;
    } scan_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [15:0] switch_value, [20:16] buttons, [23:21] zero
    logic [1:0]  s_tuser;   // [1:0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [7:0] digit_select, [15:8] segments, [31:16] led_value
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    // Mirror of the scanner state, advanced on every accepted transfer.
    logic [2:0]  scan_pos      = 3'd0;
    logic [15:0] latched       = 16'd0;
    logic [2:0]  mode          = mss_pkg::MODE_HEX;
    logic        shift_right   = 1'b0;
    logic [15:0] shift_reg     = 16'd0;
    logic [7:0]  frame_cnt     = 8'd0;
    logic [1:0]  scroll_idx    = 2'd0;
    logic [7:0]  period_model  = mss_pkg::SCROLL_PERIOD_RESET;

    scan_result_t display_q[$];
    scan_result_t oldest;

    int error_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    multimode_seven_segment_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (display_q.size() == 0)
            begin
                $error("unexpected result transfer %h", m_tdata);
                error_count++;
            end
            else
            begin
                oldest = display_q.pop_front();
                if (m_tdata[7:0] !== oldest.digit_select)
                begin
                    $error("digit_select: expected %h, got %h",
                           oldest.digit_select, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[15:8] !== oldest.segments)
                begin
                    $error("segments: expected %h, got %h", oldest.segments, m_tdata[15:8]);
                    error_count++;
                end
                if (m_tdata[31:16] !== oldest.led_value)
                begin
                    $error("led_value: expected %h, got %h", oldest.led_value, m_tdata[31:16]);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [7:0] glyph_of(input logic [3:0] nib);
        logic [7:0] g;
        case (nib)
            4'h0: g = 8'hC0;
            4'h1: g = 8'hF9;
            4'h2: g = 8'hA4;
            4'h3: g = 8'hB0;
            4'h4: g = 8'h99;
            4'h5: g = 8'h92;
            4'h6: g = 8'h82;
            4'h7: g = 8'hF8;
            4'h8: g = 8'h80;
            4'h9: g = 8'h90;
            4'hA: g = 8'h88;
            4'hB: g = 8'h83;
            4'hC: g = 8'hC6;
            4'hD: g = 8'hA1;
            4'hE: g = 8'h86;
            default: g = 8'h8E;
        endcase
        return g;
    endfunction

    // Positions 0..3 carry the nibbles, most significant first.
    function automatic logic [7:0] hex_digit_glyph(input logic [15:0] value,
                                                   input logic [2:0] pos);
        if (pos > 3'd3)
            return mss_pkg::SEG_BLANK;
        return glyph_of(4'(value >> (12 - 4 * int'(pos))));
    endfunction

    function automatic logic [15:0] pick_switch_value();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'(65536 - $urandom_range(1, 9999));
            5: return 16'(65536 - $urandom_range(10000, 32768));
            6: return 16'($urandom_range(0, 9999));
            7: return 16'(1 << $urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic predict_item(input logic [1:0] kind, input logic [15:0] sw,
                                input logic [4:0] btn);
        scan_result_t r;
        logic [7:0]   glyph;
        logic [3:0]   dig [5];
        int           mag;
        int           n;
        int           p;
        case (kind)
            mss_pkg::KIND_SWITCH: latched = sw;
            mss_pkg::KIND_BUTTON:
            begin
                if ((btn & BTN_HEX) != 0)
                begin
                    mode = mss_pkg::MODE_HEX;
                    shift_reg = latched;
                end
                else if ((btn & BTN_DEC) != 0)
                begin
                    mode = mss_pkg::MODE_DEC;
                    shift_reg = latched;
                end
                else if ((btn & BTN_SHIFT) != 0)
                begin
                    mode = mss_pkg::MODE_SHIFT;
                    shift_right = latched[15];
                    shift_reg = latched;
                end
                else if ((btn & BTN_BYTE) != 0)
                begin
                    mode = mss_pkg::MODE_BYTE;
                    shift_reg = latched;
                end
                else if ((btn & BTN_SCROLL) != 0)
                    mode = mss_pkg::MODE_SCROLL;
            end
            mss_pkg::KIND_TICK:
            begin
                glyph = mss_pkg::SEG_BLANK;
                case (mode)
                    mss_pkg::MODE_HEX: glyph = hex_digit_glyph(latched, scan_pos);
                    mss_pkg::MODE_DEC:
                    begin
                        mag = latched[15] ? 65536 - int'(latched) : int'(latched);
                        n = 0;
                        if (mag == 0)
                        begin
                            dig[0] = 4'd0;
                            n = 1;
                        end
                        else
                        begin
                            while (mag != 0 && n < 5)
                            begin
                                dig[n] = 4'(mag % 10);
                                mag = mag / 10;
                                n++;
                            end
                        end
                        if (latched[15])
                        begin
                            // A five-digit magnitude loses its leading and its last digit and
                            // overwrites the minus sign; position 3 stays blank.
                            if (scan_pos == 3'd0)
                                glyph = mss_pkg::SEG_MINUS;
                            for (int i = 0; i < n && i < 4; i++)
                            begin
                                p = 4 - n + i;
                                if (p >= 0 && p == int'(scan_pos))
                                    glyph = glyph_of(dig[n - 1 - i]);
                            end
                        end
                        else
                        begin
                            for (int i = 0; i < n; i++)
                                if (5 - n + i == int'(scan_pos))
                                    glyph = glyph_of(dig[n - 1 - i]);
                        end
                    end
                    mss_pkg::MODE_SHIFT:
                    begin
                        if (scan_pos == 3'd0 && frame_cnt == 8'd0)
                            shift_reg = shift_right ? shift_reg >> 1 : shift_reg << 1;
                        glyph = hex_digit_glyph(shift_reg, scan_pos);
                    end
                    mss_pkg::MODE_BYTE:
                        glyph = hex_digit_glyph({latched[7:0], latched[7:0]}, scan_pos);
                    mss_pkg::MODE_SCROLL:
                        // The scrolling digits 3..6 share the hex glyphs.
                        if (scan_pos < 3'd4)
                            glyph = glyph_of(4'(3 + 2'(scroll_idx + scan_pos[1:0])));
                    default: glyph = mss_pkg::SEG_BLANK;
                endcase
                r.digit_select = ~(8'h80 >> scan_pos);
                r.segments = glyph;
                r.led_value = latched;
                display_q.push_back(r);

                if (scan_pos == 3'd7)
                begin
                    scan_pos = 3'd0;
                    if (frame_cnt != 8'hFF)
                        frame_cnt++;
                    if (mode == mss_pkg::MODE_SCROLL && frame_cnt >= period_model)
                    begin
                        frame_cnt = 8'd0;
                        scroll_idx++;
                    end
                    else if (mode == mss_pkg::MODE_SHIFT)
                        frame_cnt = 8'd0;
                end
                else
                    scan_pos++;
            end
            default: ;
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    // s_tvalid stays high so back-to-back items need no extra edge.
    task automatic send_item(input logic [1:0] kind, input logic [15:0] sw,
                             input logic [4:0] btn);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {3'b000, btn, sw};
        s_tuser = kind;
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(kind, sw, btn);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (display_q.size() != 0)
            @(negedge clk);
        // Let a trailing switch or button item finish inside the block.
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_scroll_period(input logic [7:0] value);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        period_model = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Reset state, ignored kinds, an empty button press, every mode and the
    // decimal corner values, all under the reset scroll period.
    task automatic test_directed_cases();
        send_item(KIND_UNUSED, 16'hFFFF, 5'h1F);
        send_item(mss_pkg::KIND_BUTTON, 16'hFFFF, 5'd0);
        repeat (2) send_item(mss_pkg::KIND_TICK, 16'h0000, 5'd0);
        send_item(mss_pkg::KIND_SWITCH, 16'hFFFF, 5'h1F);
        repeat (2) send_item(mss_pkg::KIND_TICK, 16'hFFFF, 5'h1F);
        send_item(mss_pkg::KIND_BUTTON, 16'h0000, BTN_DEC);
        repeat (4) send_item(mss_pkg::KIND_TICK, 16'h0000, 5'd0);
        send_item(mss_pkg::KIND_SWITCH, 16'h8000, 5'd0);
        repeat (3) send_item(mss_pkg::KIND_TICK, 16'h0000, 5'd0);
        send_item(mss_pkg::KIND_BUTTON, 16'h0000, BTN_SHIFT);
        send_item(mss_pkg::KIND_TICK, 16'h0000, 5'd0);
        send_item(mss_pkg::KIND_BUTTON, 16'h0000, 5'h1F);
        send_item(mss_pkg::KIND_BUTTON, 16'h0000, BTN_BYTE | BTN_SCROLL);
        send_item(mss_pkg::KIND_TICK, 16'h0000, 5'd0);
        send_item(mss_pkg::KIND_BUTTON, 16'h0000, BTN_SCROLL);
        send_item(mss_pkg::KIND_TICK, 16'h0000, 5'd0);
    endtask

    // Mostly runs of scan ticks, broken up by switch updates, button presses
    // and the odd unused kind.
    task automatic test_random_traffic(input int item_goal, input logic [7:0] period,
                                       input int sender_idle, input int receiver_idle);
        int         sent;
        int         pick;
        int         run;
        logic [4:0] btn;
        write_scroll_period(period);
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        sent = 0;
        while (sent < item_goal)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_item(mss_pkg::KIND_SWITCH, pick_switch_value(), 5'($urandom));
                sent++;
            end
            else if (pick < 15)
            begin
                btn = $urandom_range(1) ? 5'(1 << $urandom_range(4)) : 5'($urandom_range(31));
                send_item(mss_pkg::KIND_BUTTON, 16'($urandom), btn);
                sent++;
            end
            else if (pick < 17)
                send_item(KIND_UNUSED, 16'($urandom), 5'($urandom));
            else
            begin
                run = $urandom_range(1, 20);
                repeat (run) send_item(mss_pkg::KIND_TICK, 16'($urandom), 5'($urandom));
                sent += run;
            end
        end
    endtask

    // The sender holds off in the middle of a frame until every result is in.
    task automatic test_drain_pause();
        send_item(mss_pkg::KIND_SWITCH, 16'(65536 - 9999), 5'd0);
        send_item(mss_pkg::KIND_BUTTON, 16'h0000, BTN_DEC);
        repeat (6) send_item(mss_pkg::KIND_TICK, 16'h0000, 5'd0);
        wait_drained();
        repeat (6) send_item(mss_pkg::KIND_TICK, 16'h0000, 5'd0);
    endtask

    // Forty hex frames build up the frame counter, then scroll mode with a
    // shorter period must rotate at the very next frame end.
    task automatic test_frame_carry();
        write_scroll_period(8'd32);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_item(mss_pkg::KIND_SWITCH, pick_switch_value(), 5'd0);
        send_item(mss_pkg::KIND_BUTTON, 16'h0000, BTN_HEX);
        repeat (40 * 8) send_item(mss_pkg::KIND_TICK, 16'h0000, 5'd0);
        send_item(mss_pkg::KIND_BUTTON, 16'h0000, BTN_SCROLL);
        repeat (24) send_item(mss_pkg::KIND_TICK, 16'h0000, 5'd0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 24'd0;
        s_tuser = mss_pkg::KIND_TICK;
        cfg_valid = 1'b0;
        cfg_data = 8'd0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 74;
        test_directed_cases();
        test_random_traffic(450, 8'd0, 37, 74);
        test_random_traffic(450, 8'($urandom_range(1, 3)), 74, 37);
        test_drain_pause();
        test_random_traffic(400, 8'd1, 0, 0);
        test_frame_carry();

        wait_drained();
        repeat (40) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/mss_pkg.sv
rtl/multimode_seven_segment_scanner.sv
tb/testbench.sv
